[rtl/core/cld_pkg.sv]
// Shared types and opcode constants for the CPU load/inc/dec/add subset core.
package cld_pkg;

   // Opcode patterns and the masks that select their fixed bits.
   localparam logic [7:0] MASK_LD8_IMM  = 8'hC7;
   localparam logic [7:0] OPC_LD8_IMM   = 8'h06;
   localparam logic [7:0] MASK_MOV8     = 8'hC0;
   localparam logic [7:0] OPC_MOV8      = 8'h40;
   localparam logic [7:0] MASK_PAIR_OP  = 8'hCF;
   localparam logic [7:0] OPC_LD16_IMM  = 8'h01;
   localparam logic [7:0] OPC_INC16     = 8'h03;
   localparam logic [7:0] OPC_DEC16     = 8'h0B;
   localparam logic [7:0] OPC_ADD16     = 8'h09;
   localparam logic [7:0] OPC_LD_SP_HL  = 8'hF9;

   // Eight-bit register codes as they appear in the opcode.
   localparam logic [2:0] REG_B   = 3'd0;
   localparam logic [2:0] REG_C   = 3'd1;
   localparam logic [2:0] REG_D   = 3'd2;
   localparam logic [2:0] REG_E   = 3'd3;
   localparam logic [2:0] REG_H   = 3'd4;
   localparam logic [2:0] REG_L   = 3'd5;
   localparam logic [2:0] REG_MEM = 3'd6;
   localparam logic [2:0] REG_A   = 3'd7;

   // Register pair codes.
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   // Instruction lengths in bytes.
   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   localparam int GP_COUNT = 6;

   typedef enum logic [2:0] {
      OP_LD8_IMM,
      OP_MOV8,
      OP_LD16_IMM,
      OP_INC16,
      OP_DEC16,
      OP_ADD16,
      OP_LD_SP_HL,
      OP_UNSUP
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [1:0]  pair;
      logic [1:0]  len;
   } ctrl_type;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [15:0] sp;
      logic        unsup;
   } arch_type;

endpackage

[rtl/core/cld_decode.sv]
// Opcode decoder: turns an instruction byte into operation kind, operands and length.
module cld_decode (
   input  logic [7:0]        opcode,
   output cld_pkg::ctrl_type ctrl
);
   import cld_pkg::*;

   logic [2:0] dst;
   logic [2:0] src;

   assign dst = opcode[5:3];
   assign src = opcode[2:0];

   // Match the opcode against each supported group in priority order.
   always_comb begin
      ctrl.dst  = dst;
      ctrl.src  = src;
      ctrl.pair = opcode[5:4];
      ctrl.kind = OP_UNSUP;
      ctrl.len  = LEN_NONE;
      if ((opcode & MASK_LD8_IMM) == OPC_LD8_IMM && dst != REG_MEM) begin
         ctrl.kind = OP_LD8_IMM;
         ctrl.len  = LEN_TWO;
      end else if ((opcode & MASK_MOV8) == OPC_MOV8 && dst != REG_MEM && src != REG_MEM) begin
         ctrl.kind = OP_MOV8;
         ctrl.len  = LEN_ONE;
      end else if ((opcode & MASK_PAIR_OP) == OPC_LD16_IMM) begin
         ctrl.kind = OP_LD16_IMM;
         ctrl.len  = LEN_THREE;
      end else if ((opcode & MASK_PAIR_OP) == OPC_INC16) begin
         ctrl.kind = OP_INC16;
         ctrl.len  = LEN_ONE;
      end else if ((opcode & MASK_PAIR_OP) == OPC_DEC16) begin
         ctrl.kind = OP_DEC16;
         ctrl.len  = LEN_ONE;
      end else if ((opcode & MASK_PAIR_OP) == OPC_ADD16) begin
         ctrl.kind = OP_ADD16;
         ctrl.len  = LEN_ONE;
      end else if (opcode == OPC_LD_SP_HL) begin
         ctrl.kind = OP_LD_SP_HL;
         ctrl.len  = LEN_ONE;
      end
   end

endmodule

[rtl/core/cld_exec.sv]
// Execute unit: architectural registers, the 16-bit adder and register write-back.
module cld_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cld_pkg::ctrl_type ctrl,
   input  logic [7:0]        imm_low,
   input  logic [7:0]        imm_high,
   output cld_pkg::arch_type arch
);
   import cld_pkg::*;

   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  gp_ff [GP_COUNT];
   logic [7:0]  gp_in [GP_COUNT];
   logic [15:0] sp_ff, sp_in;
   logic [15:0] pc_ff, pc_in;
   logic        unsup_ff, unsup_in;

   logic [7:0]  src8;
   logic [15:0] pair16;
   logic [15:0] hl16;
   logic [15:0] imm16;
   logic [15:0] add_a;
   logic [15:0] add_b;
   logic [15:0] sum;
   logic        wr8_en;
   logic [2:0]  wr8_code;
   logic [7:0]  wr8_data;
   logic        wr16_en;
   logic [1:0]  wr16_pair;
   logic [15:0] wr16_data;

   assign imm16 = {imm_high, imm_low};
   assign hl16  = {gp_ff[REG_H], gp_ff[REG_L]};

   // Eight-bit source register read.
   always_comb begin
      case (ctrl.src)
         REG_B:   src8 = gp_ff[REG_B];
         REG_C:   src8 = gp_ff[REG_C];
         REG_D:   src8 = gp_ff[REG_D];
         REG_E:   src8 = gp_ff[REG_E];
         REG_H:   src8 = gp_ff[REG_H];
         REG_L:   src8 = gp_ff[REG_L];
         REG_A:   src8 = acc_ff;
         default: src8 = 8'h00;
      endcase
   end

   // Register pair read.
   always_comb begin
      case (ctrl.pair)
         PAIR_BC: pair16 = {gp_ff[REG_B], gp_ff[REG_C]};
         PAIR_DE: pair16 = {gp_ff[REG_D], gp_ff[REG_E]};
         PAIR_HL: pair16 = hl16;
         PAIR_SP: pair16 = sp_ff;
         default: pair16 = 16'h0000;
      endcase
   end

   // Operand selection for the single 16-bit adder and the write-back ports.
   always_comb begin
      add_a     = pair16;
      add_b     = 16'h0001;
      wr8_en    = 1'b0;
      wr8_code  = ctrl.dst;
      wr8_data  = imm_low;
      wr16_en   = 1'b0;
      wr16_pair = ctrl.pair;
      wr16_data = imm16;
      case (ctrl.kind)
         OP_LD8_IMM: begin
            wr8_en = 1'b1;
         end
         OP_MOV8: begin
            wr8_en   = 1'b1;
            wr8_data = src8;
         end
         OP_LD16_IMM: begin
            wr16_en = 1'b1;
         end
         OP_INC16: begin
            wr16_en   = 1'b1;
            wr16_data = sum;
         end
         OP_DEC16: begin
            add_b     = 16'hFFFF;
            wr16_en   = 1'b1;
            wr16_data = sum;
         end
         OP_ADD16: begin
            add_a     = hl16;
            add_b     = pair16;
            wr16_en   = 1'b1;
            wr16_pair = PAIR_HL;
            wr16_data = sum;
         end
         OP_LD_SP_HL: begin
            wr16_en   = 1'b1;
            wr16_pair = PAIR_SP;
            wr16_data = hl16;
         end
         default: begin
            wr8_en  = 1'b0;
            wr16_en = 1'b0;
         end
      endcase
   end

   assign sum = add_a + add_b;

   // Next architectural state.
   always_comb begin
      acc_in = acc_ff;
      sp_in  = sp_ff;
      for (int i = 0; i < GP_COUNT; i++) begin
         gp_in[i] = gp_ff[i];
      end
      if (wr8_en) begin
         if (wr8_code == REG_A) begin
            acc_in = wr8_data;
         end else if (wr8_code != REG_MEM) begin
            gp_in[wr8_code] = wr8_data;
         end
      end
      if (wr16_en) begin
         if (wr16_pair == PAIR_SP) begin
            sp_in = wr16_data;
         end else begin
            gp_in[{wr16_pair, 1'b0}] = wr16_data[15:8];
            gp_in[{wr16_pair, 1'b1}] = wr16_data[7:0];
         end
      end
      pc_in    = pc_ff + {14'd0, ctrl.len};
      unsup_in = (ctrl.kind == OP_UNSUP);
   end

   // State registers, updated once per executed instruction.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 8'h00;
         sp_ff    <= 16'h0000;
         pc_ff    <= 16'h0000;
         unsup_ff <= 1'b0;
         for (int i = 0; i < GP_COUNT; i++) begin
            gp_ff[i] <= 8'h00;
         end
      end else if (advance) begin
         acc_ff   <= acc_in;
         sp_ff    <= sp_in;
         pc_ff    <= pc_in;
         unsup_ff <= unsup_in;
         for (int i = 0; i < GP_COUNT; i++) begin
            gp_ff[i] <= gp_in[i];
         end
      end
   end

   assign arch.pc    = pc_ff;
   assign arch.a     = acc_ff;
   assign arch.b     = gp_ff[REG_B];
   assign arch.c     = gp_ff[REG_C];
   assign arch.d     = gp_ff[REG_D];
   assign arch.e     = gp_ff[REG_E];
   assign arch.h     = gp_ff[REG_H];
   assign arch.l     = gp_ff[REG_L];
   assign arch.sp    = sp_ff;
   assign arch.unsup = unsup_ff;

   // An unsupported opcode leaves the program counter and stack pointer alone.
   a_unsup_holds_pc: assert property (@(posedge clock) disable iff (reset)
      advance && ctrl.kind == OP_UNSUP |=> $stable(pc_ff) && $stable(sp_ff) && unsup_ff)
      else $error("unsupported opcode changed state");

   // Without an executed instruction no architectural state moves.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pc_ff) && $stable(sp_ff) && $stable(acc_ff))
      else $error("state changed without an executed instruction");

   // Only 16-bit loads, inc/dec and LD SP,HL may change the stack pointer.
   a_sp_writers: assert property (@(posedge clock) disable iff (reset)
      advance && ctrl.kind != OP_LD16_IMM && ctrl.kind != OP_INC16 &&
      ctrl.kind != OP_DEC16 && ctrl.kind != OP_LD_SP_HL |=> $stable(sp_ff))
      else $error("stack pointer written by an instruction that does not target it");

endmodule

[rtl/core/cpu_load_incdec_add_subset.sv]
// Top level of the CPU subset core: request register, execute unit and response handshake.
//
//   Channel | Direction | Handshake             | Payload
//   req_    | in        | req_valid/req_ready   | opcode, operand_low, operand_high
//   rsp_    | out       | rsp_valid/rsp_ready   | next_pc, reg_a..reg_l, stack_ptr, unsupported
//
// One instruction is executed per clock cycle when the response side keeps up.
// The decoded request is registered, then executed into the
// architectural registers, which also serve as the response register.
// Reset clears all CPU registers, the stack pointer and the program counter to zero.
// A stalled response holds the state; the request register still takes one more request if it is empty.
module cpu_load_incdec_add_subset (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_operand_low,
   input  logic [7:0]  req_operand_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_next_pc,
   output logic [7:0]  rsp_reg_a,
   output logic [7:0]  rsp_reg_b,
   output logic [7:0]  rsp_reg_c,
   output logic [7:0]  rsp_reg_d,
   output logic [7:0]  rsp_reg_e,
   output logic [7:0]  rsp_reg_h,
   output logic [7:0]  rsp_reg_l,
   output logic [15:0] rsp_stack_ptr,
   output logic        rsp_unsupported
);
   import cld_pkg::*;

   ctrl_type   req_ctrl;
   ctrl_type   in_ctrl_ff;
   logic [7:0] in_low_ff;
   logic [7:0] in_high_ff;
   logic       in_valid_ff, in_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;
   logic       advance;
   arch_type   arch;

   // Decode the opcode as the request arrives.
   cld_decode u_decode (
      .opcode (req_opcode),
      .ctrl   (req_ctrl)
   );

   // Execute when a request is held and the response slot is free or being drained.
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Valid flags of the request register and the response.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ctrl_ff <= req_ctrl;
         in_low_ff  <= req_operand_low;
         in_high_ff <= req_operand_high;
      end
   end

   cld_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctrl     (in_ctrl_ff),
      .imm_low  (in_low_ff),
      .imm_high (in_high_ff),
      .arch     (arch)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = arch.pc;
   assign rsp_reg_a       = arch.a;
   assign rsp_reg_b       = arch.b;
   assign rsp_reg_c       = arch.c;
   assign rsp_reg_d       = arch.d;
   assign rsp_reg_e       = arch.e;
   assign rsp_reg_h       = arch.h;
   assign rsp_reg_l       = arch.l;
   assign rsp_stack_ptr   = arch.sp;
   assign rsp_unsupported = arch.unsup;

   // A held request that cannot execute stays in the request register.
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ctrl_ff))
      else $error("held request lost");

   // Every executed request shows up as a valid response in the next cycle.
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("executed request produced no response");

   // A stalled response blocks execution so the state it shows is not overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("response overwritten while stalled");

endmodule
